@@ rtl/bce_pkg.sv @@
// Shared types, opcodes and sizes for the byte CPU execute unit.
// No dependencies; every other file in rtl/ imports this package.
package bce_pkg;

  localparam int REG_COUNT_DEF = 64;
  localparam int DATA_BYTES    = 2048;
  localparam int FIELD_W       = 6;
  localparam int WORD_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int FLAG_W        = 5;

  // The store address is the 6-bit field, and the store is sized to the smaller
  // of DATA_BYTES and the field's range, so every entry of the data store is reachable.
  localparam int STORE_DEPTH = (DATA_BYTES < (1 << FIELD_W)) ? DATA_BYTES : (1 << FIELD_W);
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_MOVI = 4'd3;
  localparam logic [3:0] OP_BEQZ = 4'd4;
  localparam logic [3:0] OP_ANDI = 4'd5;
  localparam logic [3:0] OP_EOR  = 4'd6;
  localparam logic [3:0] OP_BR   = 4'd7;
  localparam logic [3:0] OP_SAL  = 4'd8;
  localparam logic [3:0] OP_SAR  = 4'd9;
  localparam logic [3:0] OP_LDR  = 4'd10;
  localparam logic [3:0] OP_STR  = 4'd11;

  // Bit positions in the flag word.
  localparam int FLAG_C = 4;
  localparam int FLAG_V = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_S = 1;
  localparam int FLAG_Z = 0;

  typedef struct packed {
    logic                     reg_written;
    logic [FIELD_W-1:0]       dest_reg;
    logic signed [BYTE_W-1:0] dest_value;
    logic                     mem_written;
    logic [FIELD_W-1:0]       mem_addr;
    logic signed [BYTE_W-1:0] mem_value;
    logic [FLAG_W-1:0]        status_flags;
    logic                     branch_taken;
    logic [WORD_W-1:0]        branch_target;
  } result_t;

  // Write-back commands from the execute logic to the two memories.
  typedef struct packed {
    logic               reg_we;
    logic [FIELD_W-1:0] reg_addr;
    logic [BYTE_W-1:0]  reg_data;
    logic               mem_we;
    logic [STORE_AW-1:0] mem_addr;
    logic [BYTE_W-1:0]  mem_data;
  } wb_t;

endpackage

@@ rtl/bce_if.sv @@
// Valid/ready channel interfaces for instruction and result beats.
// Depends on bce_pkg for field widths.
interface bce_instr_if import bce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instruction_word;
  logic [WORD_W-1:0] instruction_address;

  modport source (output valid, output instruction_word, output instruction_address,
                  input ready);
  modport sink   (input valid, input instruction_word, input instruction_address,
                  output ready);
endinterface

interface bce_result_if import bce_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     reg_written;
  logic [FIELD_W-1:0]       dest_reg;
  logic signed [BYTE_W-1:0] dest_value;
  logic                     mem_written;
  logic [FIELD_W-1:0]       mem_addr;
  logic signed [BYTE_W-1:0] mem_value;
  logic [FLAG_W-1:0]        status_flags;
  logic                     branch_taken;
  logic [WORD_W-1:0]        branch_target;

  modport source (output valid, output reg_written, output dest_reg, output dest_value,
                  output mem_written, output mem_addr, output mem_value,
                  output status_flags, output branch_taken, output branch_target,
                  input ready);
  modport sink   (input valid, input reg_written, input dest_reg, input dest_value,
                  input mem_written, input mem_addr, input mem_value,
                  input status_flags, input branch_taken, input branch_target,
                  output ready);
endinterface

@@ rtl/byte_cpu_execute_unit.sv @@
// Top level of the byte CPU execute unit.
// Depends on bce_pkg, bce_if, bce_regfile, bce_dstore and bce_alu.

// The unit executes one instruction beat per cycle in program order, unless the
// result channel stalls, and returns one result beat for each: register write,
// store write, flags and branch redirect. A beat is accepted on the cycle after
// the previous one with no gap. Its result beat passes the execute stage and
// then the output register before it appears on the result channel. The
// synchronous reads of the register file and data store are issued on the
// accepting edge. The execute stage works on that read data in the next cycle,
// and the output register then captures the beat. Writes from the executing
// instruction are bypassed into reads issued on the same edge, so dependent
// instructions run back to back with no interlock. Register file and data store
// come out of reset reading as zero through per-entry valid bits; there is no
// clearing pass, so the unit accepts beats on the first cycle after reset.
// Backpressure on the result channel holds the output register, then the
// execute stage, which in turn holds the instruction channel. While a result
// waits, one more beat can still enter an empty execute stage.
module byte_cpu_execute_unit import bce_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  bce_instr_if.sink    instr,
  bce_result_if.source result
);

  // Execute stage: instruction waiting on its memory read data.
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic [WORD_W-1:0] s1_pc;
  logic              s1_go;
  logic              accept;

  // Output register.
  logic    out_valid;
  result_t out_data;

  logic [FLAG_W-1:0] flags, flags_next;
  logic [BYTE_W-1:0] va, vb, ld;
  result_t           alu_res;
  wb_t               wb;

  // Advance the execute stage when the output register is free or draining.
  assign s1_go  = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || s1_go;
  assign accept = instr.valid && instr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= instr.instruction_word;
      s1_pc   <= instr.instruction_address;
    end
  end

  // Flags live in a plain register; only the execute stage reads or writes
  // them, so they are always current for the instruction there.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_go) begin
      flags <= flags_next;
    end
  end

  // Issue reads on acceptance; the read data is ready in the execute stage.
  bce_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (accept),
    .raddr_a (instr.instruction_word[11:6]),
    .raddr_b (instr.instruction_word[5:0]),
    .we      (s1_go && wb.reg_we),
    .waddr   (wb.reg_addr),
    .wdata   (wb.reg_data),
    .rdata_a (va),
    .rdata_b (vb)
  );

  bce_dstore u_dstore (
    .clk   (clk),
    .rst   (rst),
    .re    (accept),
    .raddr (instr.instruction_word[STORE_AW-1:0]),
    .we    (s1_go && wb.mem_we),
    .waddr (wb.mem_addr),
    .wdata (wb.mem_data),
    .rdata (ld)
  );

  bce_alu #(
    .REG_COUNT (REG_COUNT)
  ) u_alu (
    .word       (s1_word),
    .pc         (s1_pc),
    .va         (va),
    .vb         (vb),
    .ld         (ld),
    .flags      (flags),
    .flags_next (flags_next),
    .res_out    (alu_res),
    .wb         (wb)
  );

  // Hold the result beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= alu_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.reg_written   = out_data.reg_written;
  assign result.dest_reg      = out_data.dest_reg;
  assign result.dest_value    = out_data.dest_value;
  assign result.mem_written   = out_data.mem_written;
  assign result.mem_addr      = out_data.mem_addr;
  assign result.mem_value     = out_data.mem_value;
  assign result.status_flags  = out_data.status_flags;
  assign result.branch_taken  = out_data.branch_taken;
  assign result.branch_target = out_data.branch_target;

endmodule

@@ rtl/bce_regfile.sv @@
// Byte register file: two synchronous read ports, one write port.
// Depends on bce_pkg; valid bits make never-written entries read as zero.
module bce_regfile import bce_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               re,
  input  logic [FIELD_W-1:0] raddr_a,
  input  logic [FIELD_W-1:0] raddr_b,
  input  logic               we,
  input  logic [FIELD_W-1:0] waddr,
  input  logic [BYTE_W-1:0]  wdata,
  output logic [BYTE_W-1:0]  rdata_a,
  output logic [BYTE_W-1:0]  rdata_b
);

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [BYTE_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  logic              in_a, in_b;
  logic [BYTE_W-1:0] mem_a, mem_b, fwd_data;
  logic              live_a, live_b, fwd_a, fwd_b;

  assign in_a = {1'b0, raddr_a} < (FIELD_W+1)'(REG_COUNT);
  assign in_b = {1'b0, raddr_b} < (FIELD_W+1)'(REG_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (re) begin
      mem_a    <= mem[raddr_a[AW-1:0]];
      mem_b    <= mem[raddr_b[AW-1:0]];
      live_a   <= in_a && valid[raddr_a[AW-1:0]];
      live_b   <= in_b && valid[raddr_b[AW-1:0]];
      // A write landing on the same edge bypasses the array.
      fwd_a    <= we && (waddr == raddr_a);
      fwd_b    <= we && (waddr == raddr_b);
      fwd_data <= wdata;
    end
  end

  assign rdata_a = fwd_a ? fwd_data : (live_a ? mem_a : '0);
  assign rdata_b = fwd_b ? fwd_data : (live_b ? mem_b : '0);

endmodule

@@ rtl/bce_dstore.sv @@
// Byte data store: one synchronous read port, one write port.
// Depends on bce_pkg; valid bits make never-written entries read as zero.
module bce_dstore import bce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  logic [STORE_AW-1:0] raddr,
  input  logic                we,
  input  logic [STORE_AW-1:0] waddr,
  input  logic [BYTE_W-1:0]   wdata,
  output logic [BYTE_W-1:0]   rdata
);

  logic [BYTE_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;

  logic [BYTE_W-1:0] mem_q, fwd_data;
  logic              live, fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q    <= mem[raddr];
      live     <= valid[raddr];
      fwd      <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd ? fwd_data : (live ? mem_q : '0);

endmodule

@@ rtl/bce_alu.sv @@
// Execute logic: decodes one instruction and computes result, flags and write-back.
// Depends on bce_pkg for opcodes, flag positions, result_t and wb_t.
module bce_alu import bce_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic [WORD_W-1:0] word,
  input  logic [WORD_W-1:0] pc,
  input  logic [BYTE_W-1:0] va,
  input  logic [BYTE_W-1:0] vb,
  input  logic [BYTE_W-1:0] ld,
  input  logic [FLAG_W-1:0] flags,
  output logic [FLAG_W-1:0] flags_next,
  output result_t           res_out,
  output wb_t               wb
);

  logic [3:0]          op;
  logic [FIELD_W-1:0]  fa, fb;
  logic [BYTE_W-1:0]   simm, res, prod;
  logic [BYTE_W:0]     sum;
  logic [2:0]          sar_sh;
  logic                wr, mw, br, set_nz, v;
  logic [WORD_W-1:0]   target;

  assign op   = word[15:12];
  assign fa   = word[11:6];
  assign fb   = word[5:0];
  assign simm = {{(BYTE_W-FIELD_W){fb[FIELD_W-1]}}, fb};
  assign sum  = {1'b0, va} + {1'b0, vb};
  assign prod = BYTE_W'(va * vb);
  assign sar_sh = (fb >= FIELD_W'(7)) ? 3'd7 : fb[2:0];

  always_comb begin
    res        = '0;
    wr         = 1'b0;
    mw         = 1'b0;
    br         = 1'b0;
    set_nz     = 1'b0;
    target     = '0;
    flags_next = flags;
    v          = 1'b0;
    unique case (op)
      OP_ADD: begin
        res = sum[BYTE_W-1:0];
        wr  = 1'b1;
        set_nz = 1'b1;
        flags_next[FLAG_C] = sum[BYTE_W];
        v = ~(va[7] ^ vb[7]) & (va[7] ^ res[7]);
        flags_next[FLAG_V] = v;
        flags_next[FLAG_S] = res[7] ^ v;
      end
      OP_SUB: begin
        res = va - vb;
        wr  = 1'b1;
        set_nz = 1'b1;
        v = (va[7] ^ vb[7]) & (va[7] ^ res[7]);
        flags_next[FLAG_V] = v;
        flags_next[FLAG_S] = res[7] ^ v;
      end
      OP_MUL: begin
        res = prod;
        wr  = 1'b1;
        set_nz = 1'b1;
      end
      OP_MOVI: begin
        res = simm;
        wr  = 1'b1;
      end
      OP_BEQZ: begin
        if (va == '0) begin
          br     = 1'b1;
          target = pc + WORD_W'(1) + {{(WORD_W-BYTE_W){simm[BYTE_W-1]}}, simm};
        end
      end
      OP_ANDI: begin
        res = va & simm;
        wr  = 1'b1;
        set_nz = 1'b1;
      end
      OP_EOR: begin
        res = va ^ vb;
        wr  = 1'b1;
        set_nz = 1'b1;
      end
      OP_BR: begin
        br     = 1'b1;
        target = {va, vb};
      end
      OP_SAL: begin
        res = (fb >= FIELD_W'(8)) ? '0 : (va << fb[2:0]);
        wr  = 1'b1;
        set_nz = 1'b1;
      end
      OP_SAR: begin
        res = BYTE_W'($signed(va) >>> sar_sh);
        wr  = 1'b1;
        set_nz = 1'b1;
      end
      OP_LDR: begin
        res = ld;
        wr  = 1'b1;
      end
      OP_STR: begin
        mw = 1'b1;
      end
      default: begin
      end
    endcase
    if (set_nz) begin
      flags_next[FLAG_N] = res[7];
      flags_next[FLAG_Z] = (res == '0);
    end
    // Drop writes to registers past the end of the file.
    if ({1'b0, fa} >= (FIELD_W+1)'(REG_COUNT)) begin
      wr = 1'b0;
    end
  end

  always_comb begin
    wb.reg_we   = wr;
    wb.reg_addr = fa;
    wb.reg_data = res;
    wb.mem_we   = mw;
    wb.mem_addr = fb[STORE_AW-1:0];
    wb.mem_data = va;

    res_out.reg_written   = wr;
    res_out.dest_reg      = wr ? fa : '0;
    res_out.dest_value    = wr ? res : '0;
    res_out.mem_written   = mw;
    res_out.mem_addr      = mw ? fb : '0;
    res_out.mem_value     = mw ? va : '0;
    res_out.status_flags  = flags_next;
    res_out.branch_taken  = br;
    res_out.branch_target = target;
  end

endmodule
